FILE: hw/rtl/falling_fluid_grid_step_unit_defines.svh
// Assertion helpers for the grid step unit
`ifndef FALLING_FLUID_GRID_STEP_UNIT_DEFINES_SVH
`define FALLING_FLUID_GRID_STEP_UNIT_DEFINES_SVH

// same-cycle implication
`define FFGS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FFGS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/ffgs_pkg.sv
package ffgs_pkg;

    localparam int GRID_SIZE = 256;
    localparam int CW        = $clog2(GRID_SIZE);
    localparam int CELLS     = GRID_SIZE * GRID_SIZE;
    localparam int AW        = $clog2(CELLS);
    localparam int KIND_W    = 3;

    localparam logic [CW-1:0] COORD_LAST = CW'(GRID_SIZE - 1);
    localparam logic [AW-1:0] CELL_LAST  = AW'(CELLS - 1);

    localparam logic [KIND_W-1:0] KIND_EMPTY = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FLUID = 3'd2;
    localparam logic [KIND_W-1:0] KIND_MAX   = 3'd4;

    typedef enum logic [1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_GEN   = 2'd2
    } t_func;

    typedef enum logic [2:0] {
        DIR_DOWN,
        DIR_DOWN_LEFT,
        DIR_DOWN_RIGHT,
        DIR_RIGHT,
        DIR_LEFT
    } t_dir;

    typedef struct packed {
        logic          ok;
        logic [AW-1:0] addr;
    } t_tgt;

    function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] row,
                                                input logic [CW-1:0] col);
        return AW'(row) * AW'(GRID_SIZE) + AW'(col);
    endfunction

    function automatic t_dir next_dir(input t_dir d);
        t_dir n;
        case (d)
            DIR_DOWN:       n = DIR_DOWN_LEFT;
            DIR_DOWN_LEFT:  n = DIR_DOWN_RIGHT;
            DIR_DOWN_RIGHT: n = DIR_RIGHT;
            DIR_RIGHT:      n = DIR_LEFT;
            default:        n = DIR_LEFT;
        endcase
        return n;
    endfunction

endpackage

FILE: hw/rtl/falling_fluid_grid_step_unit.sv
// Falling-fluid grid on two 3-bit cell memories used in turn as current and next grid.
// After reset the current grid is cleared, one cell a cycle, and busy stays high until that
// is done. A write, or a word with an unused func code, leaves busy low; a read passes
// through a wait state. A generation copies the current grid into the other memory (one
// cell a cycle), then sweeps every cell through the single target address unit: each cell
// is read and checked, a fluid cell has its targets checked in turn (down, down-left,
// down-right, right, left), and a moved fluid has its source cleared in the next grid.
// The two memories then swap roles. The result is on the output ports for one cycle with
// o_strobe high; the receiver cannot stall it, so it must take every word as it comes.
`include "falling_fluid_grid_step_unit_defines.svh"

module falling_fluid_grid_step_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_func,
    input  logic [7:0]  i_column,
    input  logic [7:0]  i_row,
    input  logic [2:0]  i_kind,
    output logic        o_strobe,
    output logic [2:0]  o_cell_kind,
    output logic        o_done_res
);

    localparam int CW = ffgs_pkg::CW;
    localparam int AW = ffgs_pkg::AW;
    localparam int KW = ffgs_pkg::KIND_W;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RDWAIT,
        S_COPY,
        S_CDRAIN,
        S_SRC,
        S_SCHK,
        S_TRD,
        S_TCHK,
        S_CLRSRC
    } t_state;

    t_state          r_state;
    logic            r_sel;
    logic [AW-1:0]   r_cnt;
    logic [AW-1:0]   r_wa;
    logic            r_wv;
    logic [CW-1:0]   r_col;
    logic [CW-1:0]   r_row;
    ffgs_pkg::t_dir  r_dir;
    logic            r_inside;
    logic            r_strobe;
    logic [KW-1:0]   r_cell_kind;
    logic            r_done;

    logic            accept;
    logic            u_inside;
    logic [AW-1:0]   u_addr;
    logic [AW-1:0]   src_addr;
    ffgs_pkg::t_tgt  tgt;

    logic            cur_we;
    logic [AW-1:0]   cur_wa;
    logic [KW-1:0]   cur_wd;
    logic [AW-1:0]   cur_ra;
    logic [KW-1:0]   cur_rd;
    logic            nxt_we;
    logic [AW-1:0]   nxt_wa;
    logic [KW-1:0]   nxt_wd;
    logic [AW-1:0]   nxt_ra;
    logic [KW-1:0]   nxt_rd;

    logic            b0_we;
    logic [AW-1:0]   b0_wa;
    logic [KW-1:0]   b0_wd;
    logic [AW-1:0]   b0_ra;
    logic [KW-1:0]   b0_rd;
    logic            b1_we;
    logic [AW-1:0]   b1_wa;
    logic [KW-1:0]   b1_wd;
    logic [AW-1:0]   b1_ra;
    logic [KW-1:0]   b1_rd;

    logic            is_fluid;
    logic            free;
    logic            dir_last;
    logic            last_cell;
    logic            adv;
    logic            step;
    logic [CW-1:0]   n_col;
    logic [CW-1:0]   n_row;

    assign busy     = (r_state != S_IDLE);
    assign accept   = start && !busy;
    assign u_inside = (32'(i_column) < ffgs_pkg::GRID_SIZE) &&
                      (32'(i_row) < ffgs_pkg::GRID_SIZE);
    assign u_addr   = ffgs_pkg::cell_addr(CW'(i_row), CW'(i_column));
    assign src_addr = ffgs_pkg::cell_addr(r_row, r_col);

    ffgs_tgt u_tgt (
        .i_col (r_col),
        .i_row (r_row),
        .i_dir (r_dir),
        .o_tgt (tgt)
    );

    ffgs_ram #(.DW(KW), .AW(AW)) u_bank0 (
        .i_clk   (i_clk),
        .i_we    (b0_we),
        .i_waddr (b0_wa),
        .i_wdata (b0_wd),
        .i_raddr (b0_ra),
        .o_rdata (b0_rd)
    );

    ffgs_ram #(.DW(KW), .AW(AW)) u_bank1 (
        .i_clk   (i_clk),
        .i_we    (b1_we),
        .i_waddr (b1_wa),
        .i_wdata (b1_wd),
        .i_raddr (b1_ra),
        .o_rdata (b1_rd)
    );

    assign cur_rd = r_sel ? b1_rd : b0_rd;
    assign nxt_rd = r_sel ? b0_rd : b1_rd;

    assign b0_we = r_sel ? nxt_we : cur_we;
    assign b0_wa = r_sel ? nxt_wa : cur_wa;
    assign b0_wd = r_sel ? nxt_wd : cur_wd;
    assign b0_ra = r_sel ? nxt_ra : cur_ra;
    assign b1_we = r_sel ? cur_we : nxt_we;
    assign b1_wa = r_sel ? cur_wa : nxt_wa;
    assign b1_wd = r_sel ? cur_wd : nxt_wd;
    assign b1_ra = r_sel ? cur_ra : nxt_ra;

    assign is_fluid  = (cur_rd == ffgs_pkg::KIND_FLUID);
    assign free      = (cur_rd == ffgs_pkg::KIND_EMPTY) && (nxt_rd == ffgs_pkg::KIND_EMPTY);
    assign dir_last  = (r_dir == ffgs_pkg::DIR_LEFT);
    assign last_cell = (r_col == ffgs_pkg::COORD_LAST) && (r_row == '0);

    assign adv  = ((r_state == S_SCHK) && !is_fluid) ||
                  ((r_state == S_TRD) && !tgt.ok && dir_last) ||
                  ((r_state == S_TCHK) && !free && dir_last) ||
                  (r_state == S_CLRSRC);
    assign step = ((r_state == S_TRD) && !tgt.ok && !dir_last) ||
                  ((r_state == S_TCHK) && !free && !dir_last);

    always_comb begin
        if (r_col == ffgs_pkg::COORD_LAST) begin
            n_col = '0;
            n_row = r_row - CW'(1);
        end else begin
            n_col = r_col + CW'(1);
            n_row = r_row;
        end
    end

    always_comb begin
        cur_we = 1'b0;
        cur_wa = u_addr;
        cur_wd = i_kind;
        cur_ra = u_addr;
        nxt_we = r_wv;
        nxt_wa = r_wa;
        nxt_wd = cur_rd;
        nxt_ra = tgt.addr;
        case (r_state)
            S_CLEAR: begin
                cur_we = 1'b1;
                cur_wa = r_cnt;
                cur_wd = ffgs_pkg::KIND_EMPTY;
            end
            S_IDLE: begin
                cur_we = accept && (i_func == ffgs_pkg::FUNC_WRITE) && u_inside &&
                         (i_kind <= ffgs_pkg::KIND_MAX);
            end
            S_COPY: begin
                cur_ra = r_cnt;
            end
            S_SRC: begin
                cur_ra = src_addr;
            end
            S_TRD: begin
                cur_ra = tgt.addr;
            end
            S_TCHK: begin
                nxt_we = free;
                nxt_wa = tgt.addr;
                nxt_wd = ffgs_pkg::KIND_FLUID;
            end
            S_CLRSRC: begin
                nxt_we = 1'b1;
                nxt_wa = src_addr;
                nxt_wd = ffgs_pkg::KIND_EMPTY;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_cnt    <= '0;
            r_sel    <= 1'b0;
            r_wv     <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            r_wv     <= (r_state == S_COPY);
            case (r_state)
                S_CLEAR: begin
                    r_cnt <= r_cnt + AW'(1);
                    if (r_cnt == ffgs_pkg::CELL_LAST) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_cell_kind <= ffgs_pkg::KIND_EMPTY;
                        r_done      <= 1'b1;
                        case (ffgs_pkg::t_func'(i_func))
                            ffgs_pkg::FUNC_WRITE: begin
                                r_strobe <= 1'b1;
                            end
                            ffgs_pkg::FUNC_READ: begin
                                r_inside <= u_inside;
                                r_state  <= S_RDWAIT;
                            end
                            ffgs_pkg::FUNC_GEN: begin
                                r_cnt   <= '0;
                                r_state <= S_COPY;
                            end
                            default: begin
                                r_strobe <= 1'b1;
                                r_done   <= 1'b0;
                            end
                        endcase
                    end
                end
                S_RDWAIT: begin
                    r_strobe    <= 1'b1;
                    r_cell_kind <= r_inside ? cur_rd : ffgs_pkg::KIND_EMPTY;
                    r_state     <= S_IDLE;
                end
                S_COPY: begin
                    r_wa  <= r_cnt;
                    r_cnt <= r_cnt + AW'(1);
                    if (r_cnt == ffgs_pkg::CELL_LAST) begin
                        r_state <= S_CDRAIN;
                    end
                end
                S_CDRAIN: begin
                    r_row   <= ffgs_pkg::COORD_LAST;
                    r_col   <= '0;
                    r_state <= S_SRC;
                end
                S_SRC: begin
                    r_state <= S_SCHK;
                end
                S_SCHK: begin
                    if (is_fluid) begin
                        r_dir   <= ffgs_pkg::DIR_DOWN;
                        r_state <= S_TRD;
                    end
                end
                S_TRD: begin
                    if (tgt.ok) begin
                        r_state <= S_TCHK;
                    end
                end
                S_TCHK: begin
                    if (free) begin
                        r_state <= S_CLRSRC;
                    end else begin
                        r_state <= S_TRD;
                    end
                end
                default: begin
                end
            endcase

            if (step) begin
                r_dir   <= ffgs_pkg::next_dir(r_dir);
                r_state <= S_TRD;
            end

            if (adv) begin
                if (last_cell) begin
                    r_sel       <= ~r_sel;
                    r_strobe    <= 1'b1;
                    r_cell_kind <= ffgs_pkg::KIND_EMPTY;
                    r_done      <= 1'b1;
                    r_state     <= S_IDLE;
                end else begin
                    r_col   <= n_col;
                    r_row   <= n_row;
                    r_state <= S_SRC;
                end
            end
        end
    end

    assign o_strobe    = r_strobe;
    assign o_cell_kind = r_cell_kind;
    assign o_done_res  = r_done;

    `FFGS_ASSERT_IMP(a_strobe_idle, i_clk, i_rst_n, o_strobe, !busy, "result word while busy")
    `FFGS_ASSERT_NXT(a_gen_busy, i_clk, i_rst_n,
        accept && (i_func == ffgs_pkg::FUNC_GEN), busy, "generation not started")
    `FFGS_ASSERT_IMP(a_swap_done, i_clk, i_rst_n, r_sel != $past(r_sel),
        o_strobe && o_done_res, "grid swap without result")
    `FFGS_ASSERT_IMP(a_move_inside, i_clk, i_rst_n, (r_state == S_TCHK) && nxt_we,
        tgt.ok, "fluid moved outside grid")

endmodule

FILE: hw/rtl/ffgs_ram.sv
module ffgs_ram #(
    parameter int DW = 3,
    parameter int AW = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/ffgs_tgt.sv
module ffgs_tgt (
    input  logic [ffgs_pkg::CW-1:0] i_col,
    input  logic [ffgs_pkg::CW-1:0] i_row,
    input  ffgs_pkg::t_dir          i_dir,
    output ffgs_pkg::t_tgt          o_tgt
);

    logic [ffgs_pkg::CW-1:0] tc;
    logic [ffgs_pkg::CW-1:0] tr;
    logic                    ok;
    logic                    row_last;
    logic                    col_last;
    logic                    col_first;

    assign row_last  = (i_row == ffgs_pkg::COORD_LAST);
    assign col_last  = (i_col == ffgs_pkg::COORD_LAST);
    assign col_first = (i_col == '0);

    always_comb begin
        tc = i_col;
        tr = i_row;
        ok = 1'b0;
        case (i_dir)
            ffgs_pkg::DIR_DOWN: begin
                ok = !row_last;
                tr = i_row + ffgs_pkg::CW'(1);
            end
            ffgs_pkg::DIR_DOWN_LEFT: begin
                ok = !row_last && !col_first;
                tr = i_row + ffgs_pkg::CW'(1);
                tc = i_col - ffgs_pkg::CW'(1);
            end
            ffgs_pkg::DIR_DOWN_RIGHT: begin
                ok = !row_last && !col_last;
                tr = i_row + ffgs_pkg::CW'(1);
                tc = i_col + ffgs_pkg::CW'(1);
            end
            ffgs_pkg::DIR_RIGHT: begin
                ok = !col_last;
                tc = i_col + ffgs_pkg::CW'(1);
            end
            ffgs_pkg::DIR_LEFT: begin
                ok = !col_first;
                tc = i_col - ffgs_pkg::CW'(1);
            end
            default: begin
                ok = 1'b0;
            end
        endcase
    end

    assign o_tgt.ok   = ok;
    assign o_tgt.addr = ffgs_pkg::cell_addr(tr, tc);

endmodule
